### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SHE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHE_ASSERT_IMP(lbl, ante, cons)
`define SHE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/she_pkg.sv
// ----------------------------------------------------------------------------
// she_pkg
// Shared types and the standard substitution, linear and round-constant tables.
// ----------------------------------------------------------------------------
package she_pkg;

  localparam int WordsPerBlock = 8;
  localparam int RoundCount    = 12;

  typedef logic [WordsPerBlock-1:0][63:0] blk_t;

  localparam logic [63:0] IV_SHORT = 64'h0101010101010101;

  localparam logic [7:0] SBOX [256] = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  localparam logic [63:0] LIN_ROWS [64] = '{
    64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
    64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
    64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
    64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
    64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
    64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
    64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
    64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
    64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
    64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
    64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
    64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
    64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
    64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
  };

  // least significant word first
  localparam logic [63:0] RCONST [RoundCount][WordsPerBlock] = '{
    '{64'hdd806559f2a64507,64'h05767436cc744d23,64'ha2422a08a460d315,64'h4b7ce09192676901,
      64'h714eb88d7585c4fc,64'h2f6a76432e45d016,64'hebcb2f81c0657c1f,64'hb1085bda1ecadae9},
    '{64'he679047021b19bb7,64'h55dda21bd7cbcd56,64'h5cb561c2db0aa7ca,64'h9ab5176b12d69958,
      64'h61d55e0f16b50131,64'hf3feea720a232b98,64'h4fe39d460f70b5d7,64'h6fa3b58aa99d2f1a},
    '{64'h991e96f50aba0ab2,64'hc2b6f443867adb31,64'hc1c93a376062db09,64'hd3e20fe490359eb1,
      64'hf2ea7514b1297b7b,64'h06f15e5f529c1f8b,64'h0a39fc286a3d8435,64'hf574dcac2bce2fc7},
    '{64'h220cbebc84e3d12e,64'h3453eaa193e837f1,64'hd8b71333935203be,64'ha9d72c82ed03d675,
      64'h9d721cad685e353f,64'h488e857e335c3c7d,64'hf948e1a05d71e4dd,64'hef1fdfb3e81566d2},
    '{64'h601758fd7c6cfe57,64'h7a56a27ea9ea63f5,64'hdfff00b723271a16,64'hbfcd1747253af5a3,
      64'h359e35d7800fffbd,64'h7f151c1f1686104a,64'h9a3f410c6ca92363,64'h4bea6bacad474799},
    '{64'hfa68407a46647d6e,64'hbf71c57236904f35,64'h0af21f66c2bec6b6,64'hcffaa6b71c9ab7b4,
      64'h187f9ab49af08ec6,64'h2d66c4f95142a46c,64'h6fa4c33b7a3039c0,64'hae4faeae1d3ad3d9},
    '{64'h8886564d3a14d493,64'h3517454ca23c4af3,64'h06476983284a0504,64'h0992abc52d822c37,
      64'hd3473e33197a93c9,64'h399ec6c7e6bf87c9,64'h51ac86febf240954,64'hf4c70e16eeaac5ec},
    '{64'ha47f0dd4bf02e71e,64'h36acc2355951a8d9,64'h69d18d2bd1a5c42f,64'hf4892bcb929b0690,
      64'h89b4443b4ddbc49a,64'h4eb7f8719c36de1e,64'h03e7aa020c6e4141,64'h9b1f5b424d93c9a7},
    '{64'h7261445183235adb,64'h0e38dc92cb1f2a60,64'h7b2b8a9aa6079c54,64'h800a440bdbb2ceb1,
      64'h3cd955b7e00d0984,64'h3a7d3a1b25894224,64'h944c9ad8ec165fde,64'h378f5a541631229b},
    '{64'h74b4c7fb98459ced,64'h3698fad1153bb6c3,64'h7a1e6c303b7652f4,64'h9fe76702af69334b,
      64'h1fffe18a1b336103,64'h8941e71cff8a78db,64'h382ae548b2e4f3f3,64'habbedea680056f52},
    '{64'h6bcaa4cd81f32d1b,64'hdea2594ac06fd85d,64'hefbacd1d7d476e98,64'h8a1d71efea48b9ca,
      64'h2001802114846679,64'hd8fa6bbbebab0761,64'h3002c6cd635afe94,64'h7bcd9ed0efc889fb},
    '{64'h48bc924af11bd720,64'hfaf417d5d9b21b99,64'he71da4aa88e12852,64'h5d80ef9d1891cc86,
      64'hf82012d430219f9b,64'hcda43c32bcdf1d77,64'hd21380b00449b17a,64'h378ee767f11631ba}
  };

  // One output word of LPS: substitute byte r of every word, then apply L.
  function automatic logic [63:0] lps_row(input blk_t x, input logic [2:0] r);
    logic [63:0] b;
    logic [63:0] acc;
    b   = '0;
    acc = '0;
    for (int c = 0; c < WordsPerBlock; c++) begin
      b[8*c +: 8] = SBOX[x[c][{r, 3'b000} +: 8]];
    end
    for (int k = 0; k < 64; k++) begin
      if (b[63-k]) acc ^= LIN_ROWS[k];
    end
    return acc;
  endfunction

endpackage

### rtl/streebog_hash_engine.sv
// ----------------------------------------------------------------------------
// streebog_hash_engine
// 512/256-bit hash engine: word buffer, one shared LPS row unit, serial adders.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in_     | in  | in_valid/in_stall   | kind, word, bit_count
//  out_    | out | out_valid/out_stall | digest_word, digest_last
//  cfg_    | in  | cfg_wr_en           | cfg_wr_data (short_digest)
//
// Words 1..7 of a block go straight into the word buffer. The eighth word starts the
// compression: one LPS row per cycle from a single row unit, 25 LPS passes,
// so each block runs load, the LPS row passes, fold and the N and Sigma adds.
// A final block adds a pad step and two more compressions,
// before the digest items stream out, one per cycle when not stalled.
// Reset (synchronous, rst_n low) selects the 512-bit mode with zero IV.
// in_stall is high for the whole of a compression and the digest output.
module streebog_hash_engine
  import she_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_word,
  input  logic [8:0]  in_bit_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic        out_digest_last
);
`include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_LPS, S_FOLD, S_ADD, S_OUT
  } state_t;

  // what the LPS unit is working on
  typedef enum logic [1:0] {M_KEYINIT, M_BLK, M_KEY} mode_t;

  // which compression is running
  typedef enum logic [1:0] {P_ABSORB, P_FIN_N, P_FIN_S} phase_t;

  state_t       state_r;
  mode_t        mode_r;
  phase_t       phase_r;
  logic         short_r;
  logic         final_r;
  logic [8:0]   bc_r;
  logic [2:0]   idx_r;
  logic [2:0]   row_r;
  logic [3:0]   round_r;
  logic [2:0]   cnt_r;
  logic [2:0]   optr_r;
  logic         cy_n_r;
  logic         cy_s_r;
  blk_t         h_r, n_r, sig_r;
  blk_t         mbuf_r, k_r, w_r, tmp_r;

  blk_t         lps_in;
  blk_t         lps_done;
  blk_t         n_sel;
  blk_t         m_sel;
  logic [63:0]  row_out;
  logic [63:0]  len_word;
  logic [64:0]  sum_n;
  logic [64:0]  sum_s;
  logic [63:0]  iv;

  assign iv = short_r ? IV_SHORT : '0;

  // LPS operand
  always_comb begin
    for (int c = 0; c < WordsPerBlock; c++) begin
      case (mode_r)
        M_BLK:   lps_in[c] = w_r[c] ^ k_r[c];
        M_KEY:   lps_in[c] = k_r[c] ^ RCONST[round_r][c];
        default: lps_in[c] = k_r[c];
      endcase
    end
  end

  assign row_out = lps_row(lps_in, row_r);

  always_comb begin
    lps_done    = tmp_r;
    lps_done[7] = row_out;
  end

  // compression operands: g_N(h, m) while absorbing, then g_0(h, N), g_0(h, Sigma)
  always_comb begin
    unique case (phase_r)
      P_ABSORB: begin n_sel = n_r; m_sel = mbuf_r; end
      P_FIN_N:  begin n_sel = '0;  m_sel = n_r;    end
      default:  begin n_sel = '0;  m_sel = sig_r;  end
    endcase
  end

  assign len_word = (cnt_r != 3'd0) ? 64'd0
                  : (final_r ? {55'd0, bc_r} : 64'd512);
  assign sum_n = {1'b0, n_r[cnt_r]} + {1'b0, len_word} + {64'd0, cy_n_r};
  assign sum_s = {1'b0, sig_r[cnt_r]} + {1'b0, mbuf_r[cnt_r]} + {64'd0, cy_s_r};

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = h_r[optr_r];
  assign out_digest_last = (optr_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_KEYINIT;
      phase_r <= P_ABSORB;
      short_r <= 1'b0;
      final_r <= 1'b0;
      idx_r   <= '0;
      row_r   <= '0;
      round_r <= '0;
      cnt_r   <= '0;
      optr_r  <= '0;
      cy_n_r  <= 1'b0;
      cy_s_r  <= 1'b0;
      h_r     <= '0;
      n_r     <= '0;
      sig_r   <= '0;
    end else if (cfg_wr_en) begin
      // new mode, chain restarts
      short_r <= cfg_wr_data;
      idx_r   <= '0;
      h_r     <= {WordsPerBlock{cfg_wr_data ? IV_SHORT : 64'd0}};
      n_r     <= '0;
      sig_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mbuf_r[idx_r] <= in_word;
            idx_r         <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              final_r <= in_kind;
              bc_r    <= in_bit_count;
              phase_r <= P_ABSORB;
              state_r <= in_kind ? S_PAD : S_LOAD;
            end
          end
        end
        S_PAD: begin
          // zeros above the count, a one at the count
          for (int i = 0; i < WordsPerBlock; i++) begin
            if (bc_r[8:6] == 3'(i)) begin
              mbuf_r[i] <= (mbuf_r[i] & ((64'd1 << bc_r[5:0]) - 64'd1))
                         | (64'd1 << bc_r[5:0]);
            end else if (bc_r[8:6] < 3'(i)) begin
              mbuf_r[i] <= '0;
            end
          end
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          k_r     <= h_r ^ n_sel;
          w_r     <= m_sel;
          mode_r  <= M_KEYINIT;
          row_r   <= '0;
          round_r <= '0;
          state_r <= S_LPS;
        end
        S_LPS: begin
          tmp_r[row_r] <= row_out;
          row_r        <= row_r + 3'd1;
          if (row_r == 3'd7) begin
            unique case (mode_r)
              M_KEYINIT: begin
                k_r    <= lps_done;
                mode_r <= M_BLK;
              end
              M_BLK: begin
                w_r    <= lps_done;
                mode_r <= M_KEY;
              end
              default: begin
                k_r    <= lps_done;
                mode_r <= M_BLK;
                if (round_r == 4'(RoundCount - 1)) begin
                  state_r <= S_FOLD;
                end else begin
                  round_r <= round_r + 4'd1;
                end
              end
            endcase
          end
        end
        S_FOLD: begin
          h_r     <= h_r ^ w_r ^ k_r ^ m_sel;
          round_r <= '0;
          unique case (phase_r)
            P_ABSORB: begin
              cnt_r   <= '0;
              cy_n_r  <= 1'b0;
              cy_s_r  <= 1'b0;
              state_r <= S_ADD;
            end
            P_FIN_N: begin
              phase_r <= P_FIN_S;
              state_r <= S_LOAD;
            end
            default: begin
              optr_r  <= short_r ? 3'd4 : 3'd0;
              state_r <= S_OUT;
            end
          endcase
        end
        S_ADD: begin
          // N and Sigma, one word per cycle with ripple carry
          n_r[cnt_r]   <= sum_n[63:0];
          sig_r[cnt_r] <= sum_s[63:0];
          cy_n_r       <= sum_n[64];
          cy_s_r       <= sum_s[64];
          cnt_r        <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            if (final_r) begin
              phase_r <= P_FIN_N;
              state_r <= S_LOAD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            optr_r <= optr_r + 3'd1;
            if (optr_r == 3'd7) begin
              h_r     <= {WordsPerBlock{iv}};
              n_r     <= '0;
              sig_r   <= '0;
              idx_r   <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SHE_ASSERT_IMP(a_round_range, 1'b1, round_r < 4'(RoundCount))
  `SHE_ASSERT_IMP(a_first_word, $rose(out_valid), optr_r == {short_r, 2'b00})
  `SHE_ASSERT_NXT(a_out_done, out_valid && !out_stall && out_digest_last, !out_valid)
  `SHE_ASSERT_NXT(a_block_busy, in_valid && !in_stall && idx_r == 3'd7 && !cfg_wr_en,
                  in_stall)

endmodule

### test/streebog_digest_checker.sv
// ----------------------------------------------------------------------------
// streebog_digest_checker
// Watches both channels and the mode port, predicts the digest words of
// each message and compares every accepted result item with them.
// ----------------------------------------------------------------------------
module streebog_digest_checker
  import she_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_word,
  input  logic [8:0]  in_bit_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_digest_word,
  input  logic        out_digest_last,
  output int          errors,
  output int          pending,
  output int          digests_seen
);

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } digest_item_t;

  digest_item_t digest_due[$];

  logic       short_mode;
  blk_t       chain, bit_total, block_total, msg_buf;
  logic [2:0] word_pos;

  assign pending = digest_due.size();

  task automatic flag_mismatch(input string what);
    $display("  checker: %s (t=%0t)", what, $realtime);
    errors++;
  endtask

  function automatic blk_t lps(input blk_t v);
    blk_t        t;
    logic [63:0] b;
    logic [63:0] acc;
    for (int r = 0; r < WordsPerBlock; r++) begin
      for (int c = 0; c < WordsPerBlock; c++) begin
        b[8*c +: 8] = SBOX[v[c][8*r +: 8]];
      end
      acc = '0;
      for (int k = 0; k < 64; k++) begin
        if (b[63-k]) acc ^= LIN_ROWS[k];
      end
      t[r] = acc;
    end
    return t;
  endfunction

  // h = g_n(h, m)
  function automatic blk_t g_step(input blk_t h, input blk_t n, input blk_t m);
    blk_t key, state, rc;
    key   = lps(h ^ n);
    state = m;
    for (int i = 0; i < RoundCount; i++) begin
      for (int j = 0; j < WordsPerBlock; j++) rc[j] = RCONST[i][j];
      state = lps(state ^ key);
      key   = lps(key ^ rc);
    end
    return h ^ state ^ key ^ m;
  endfunction

  task automatic restart_chain();
    chain       = short_mode ? {WordsPerBlock{IV_SHORT}} : '0;
    bit_total   = '0;
    block_total = '0;
    word_pos    = '0;
  endtask

  task automatic take_word(input logic kind, input logic [63:0] w, input logic [8:0] bc);
    blk_t mask;
    int   first;
    msg_buf[word_pos] = w;
    if (word_pos != 3'd7) begin
      word_pos++;
      return;
    end
    word_pos = '0;
    if (!kind) begin
      chain       = g_step(chain, bit_total, msg_buf);
      bit_total   = bit_total + 512;
      block_total = block_total + msg_buf;
      return;
    end
    // pad: clear above the bit count, then a single 1 at it
    mask    = (blk_t'(1) << bc) - 1;
    msg_buf = (msg_buf & mask) | (blk_t'(1) << bc);
    chain       = g_step(chain, bit_total, msg_buf);
    bit_total   = bit_total + bc;
    block_total = block_total + msg_buf;
    chain = g_step(chain, '0, bit_total);
    chain = g_step(chain, '0, block_total);
    first = short_mode ? 4 : 0;
    for (int k = first; k < WordsPerBlock; k++) begin
      digest_due.push_back('{word: chain[k], last: (k == WordsPerBlock - 1)});
    end
    restart_chain();
  endtask

  always @(posedge clk) begin
    digest_item_t exp_item;
    if (!rst_n) begin
      short_mode = 1'b0;
      msg_buf    = '0;
      restart_chain();
    end else begin
      if (cfg_wr_en) begin
        short_mode = cfg_wr_data;
        restart_chain();
      end
      if (in_valid && !in_stall) take_word(in_kind, in_word, in_bit_count);
      if (out_valid && !out_stall) begin
        if (digest_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected item %h", out_digest_word));
        end else begin
          exp_item = digest_due.pop_front();
          if (out_digest_word !== exp_item.word)
            flag_mismatch($sformatf("digest_word %h, want %h",
                                    out_digest_word, exp_item.word));
          if (out_digest_last !== exp_item.last)
            flag_mismatch($sformatf("digest_last %b, want %b",
                                    out_digest_last, exp_item.last));
          if (exp_item.last) digests_seen++;
        end
      end
    end
  end

  initial begin
    errors       = 0;
    digests_seen = 0;
  end

endmodule

### test/tb_streebog_hash_engine.sv
// ----------------------------------------------------------------------------
// tb_streebog_hash_engine
// Drives messages into the hash engine in both digest modes, with random
// gaps and stalls; the checker beside the engine compares the digests.
// ----------------------------------------------------------------------------
module tb_streebog_hash_engine;

  localparam int CycleLimit = 1000000;
  localparam int IdlePct    = 27;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [63:0] in_word = '0;
  logic [8:0]  in_bit_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_word;
  logic        out_digest_last;

  int errors, pending, digests_seen;
  int cycle_count = 0;
  int rand_items  = 0;
  int messages    = 0;
  bit tx_idle_on  = 1'b1;   // sender gaps allowed
  bit hold_req    = 1'b0;   // ask the receiver for one long hold-off
  bit hold_on     = 1'b0;

  always #5 clk = ~clk;

  streebog_hash_engine dut (.*);

  streebog_digest_checker u_checker (.*);

  // watchdog: a hung engine must not hang the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count, pending);
      $display("streebog_hash_engine: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, a quiet window with none, one long hold-off
  always @(negedge clk) begin
    if (hold_on) out_stall = 1'b1;
    else if (cycle_count > 2000 && cycle_count < 4500) out_stall = 1'b0;
    else out_stall = ($urandom_range(0, 99) < IdlePct);
  end

  // long hold-off, counted here so the sender keeps offering items meanwhile
  initial begin
    wait (hold_req);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (2500) @(negedge clk);
    hold_on = 1'b0;
  end

  // offer one item at a falling edge; returns at the falling edge after it
  // was taken, with valid still high so back-to-back items need no toggle
  task automatic put_item(input logic kind, input logic [63:0] w, input logic [8:0] bc);
    bit taken;
    while (tx_idle_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_kind      = kind;
    in_word      = w;
    in_bit_count = bc;
    in_valid     = 1'b1;
    do begin
      #1 taken = !in_stall;
      @(negedge clk);
    end while (!taken);
  endtask

  // stop offering, let every digest arrive, then allow the engine to settle
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_mode(input logic short_digest);
    cfg_wr_data = short_digest;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // message of full blocks then the final block; early words get a random
  // kind since only the eighth word of a block decides its handling
  task automatic put_message(input int full_blocks, input logic [8:0] bc, input bit count_it);
    for (int b = 0; b <= full_blocks; b++) begin
      for (int i = 0; i < 8; i++) begin
        put_item(i == 7 ? (b == full_blocks) : logic'($urandom_range(0, 1)),
                 rand_word(), (i == 7 && b == full_blocks) ? bc : 9'($urandom));
        if (count_it) rand_items++;
      end
    end
    messages++;
  endtask

  function automatic logic [8:0] rand_bit_count();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd511;
      2:       return 9'd64;
      3:       return 9'd63;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    set_mode(1'b0);

    // directed, long mode: empty message with a full-ones buffer the pad
    // must clear, then a block of zeros with mixed kinds before a final
    // block holding the widest bit count
    for (int i = 0; i < 8; i++) put_item(i == 7, '1, 9'd0);
    for (int i = 0; i < 8; i++) put_item(i < 7 && i[0], '0, 9'h1FF);
    for (int i = 0; i < 8; i++) put_item(1'b1, '1, 9'd511);
    messages += 2;
    drain();

    // random part over both modes
    for (int phase = 0; phase < 3; phase++) begin
      set_mode(phase != 1 ? 1'b1 : 1'b0);
      while (rand_items < 48 * (phase + 1)) begin
        tx_idle_on = !(rand_items > 70 && rand_items < 110);
        if (phase == 1 && rand_items > 80) hold_req = 1'b1;
        put_message($urandom_range(0, 3) == 0 ? 2 : $urandom_range(0, 1),
                    rand_bit_count(), 1'b1);
        // once, the sender waits for every digest before going on
        if (phase == 0 && messages == 5) drain();
      end
      drain();
    end

    $display("%0d messages, %0d random items, %0d digests checked in both modes",
             messages, rand_items, digests_seen);
    $display("long output hold-off and full drains included, %0d cycles", cycle_count);
    if (errors == 0) begin
      $display("streebog_hash_engine: match");
    end else begin
      $display("%0d mismatches", errors);
      $display("streebog_hash_engine: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/she_pkg.sv
rtl/streebog_hash_engine.sv
test/streebog_digest_checker.sv
test/tb_streebog_hash_engine.sv
